[hw/rtl/cpss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera power and shutter sequencer package
// Shared payload types, register indexes, sequencer modes and timing constants.
// ----------------------------------------------------------------------------
package cpss_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 21;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_ALT_CM          = 3'd0,
        CFG_SHOT_GAP_TICKS      = 3'd1,
        CFG_STAGE_PHOTO_COUNT   = 3'd2,
        CFG_NAV_SHOTS_ENABLE    = 3'd3,
        CFG_MANUAL_SHOTS_ENABLE = 3'd4
    } cfg_index_t;

    // Sequencer modes.
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_TURN_ON  = 3'd1,
        MODE_SHOT     = 3'd2,
        MODE_TURN_OFF = 3'd3,
        MODE_PAUSE    = 3'd4
    } mode_t;

    // Countdown loads and the points inside them where pins change.
    localparam logic [7:0] TURN_ON_TICKS      = 8'd38;
    localparam logic [7:0] TURN_ON_PULSE_END  = 8'd32;
    localparam logic [7:0] TURN_OFF_TICKS     = 8'd28;
    localparam logic [7:0] TURN_OFF_PULSE_ON  = 8'd16;
    localparam logic [7:0] TURN_OFF_PULSE_END = 8'd10;
    localparam logic [7:0] SHOT_TICKS         = 8'd6;
    localparam logic [7:0] SHOT_PULSE_END     = 8'd2;
    localparam logic [3:0] DESCENT_HOLD_TICKS = 4'd10;

    // Altitude hysteresis band and steep sink threshold.
    localparam logic signed [24:0] ALT_BAND_CM     = 25'sd200;
    localparam logic signed [15:0] STEEP_SINK_CM_S = -16'sd500;

    // Configuration reset values.
    localparam logic signed [20:0] MIN_ALT_CM_RESET        = 21'sd300;
    localparam logic [7:0]         SHOT_GAP_RESET          = 8'd16;
    localparam logic [7:0]         STAGE_PHOTO_COUNT_RESET = 8'd3;

    // One input beat: a navigation tick.
    typedef struct packed {
        logic               fix_valid;
        logic signed [23:0] altitude_cm;
        logic signed [15:0] climb_rate_cm_s;
        logic               nav_mode;
        logic               camera_sense;
    } tick_in_t;

    // One result beat.
    typedef struct packed {
        logic        shutter_level;
        logic        power_switch_level;
        logic [2:0]  sequencer_mode;
        logic        shot_strobe;
        logic [15:0] photo_number;
        logic        camera_wanted;
    } tick_out_t;

endpackage

[hw/rtl/camera_power_and_shutter_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera power and shutter sequencer
// Altitude and descent gating of camera power, with a countdown sequencer
// driving the power button pulse, the shutter pin and numbered shot strobes.
// ----------------------------------------------------------------------------
// A result beat passes from the input register to the result register when the
// result register is free; a stalled result holds the next tick.
// Throughput: one tick per cycle while the result register is free or being emptied;
// the whole step is one registered pass between the input register and the result register.
// Reset: synchronous, active low aresetn; it restores every state and
// configuration register to its power-up value.
module camera_power_and_shutter_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input tick channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cpss_pkg::tick_in_t                s_data,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output cpss_pkg::tick_out_t               m_data,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cpss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Handshake and pipeline registers.
    logic                 in_valid_reg;
    cpss_pkg::tick_in_t   in_data_reg;
    logic                 out_valid_reg;
    cpss_pkg::tick_out_t  out_data_reg;
    cpss_pkg::tick_out_t  out_data_next;
    logic                 advance;

    // Configuration registers.
    logic signed [20:0]   min_alt_cm_reg;
    logic [7:0]           shot_gap_reg;
    logic [7:0]           stage_photo_count_reg;
    logic                 nav_shots_enable_reg;
    logic                 manual_shots_enable_reg;

    // Sequencer state.
    cpss_pkg::mode_t      mode_reg,        mode_next;
    logic [7:0]           countdown_reg,   countdown_next;
    logic                 alt_enable_reg,  alt_enable_next;
    logic [3:0]           descent_hold_reg, descent_hold_next;
    logic                 shoot_en_reg,    shoot_en_next;
    logic [7:0]           stage_count_reg, stage_count_next;
    logic [15:0]          photo_num_reg,   photo_num_next;
    logic                 shutter_reg,     shutter_next;
    logic                 switch_reg,      switch_next;

    // Step temporaries.
    logic signed [24:0]   alt_ext;
    logic signed [24:0]   min_alt_ext;
    logic signed [24:0]   alt_upper;
    logic                 wanted;
    logic                 allowed;
    logic                 strobe;
    logic [15:0]          photo;
    cpss_pkg::mode_t      want_mode;

    // The step runs when the input register holds a beat and the result
    // register is free or being emptied this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_alt_cm_reg          <= cpss_pkg::MIN_ALT_CM_RESET;
            shot_gap_reg            <= cpss_pkg::SHOT_GAP_RESET;
            stage_photo_count_reg   <= cpss_pkg::STAGE_PHOTO_COUNT_RESET;
            nav_shots_enable_reg    <= 1'b0;
            manual_shots_enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cpss_pkg::CFG_MIN_ALT_CM: begin
                    min_alt_cm_reg <= $signed(cfg_data);
                end
                cpss_pkg::CFG_SHOT_GAP_TICKS: begin
                    shot_gap_reg <= cfg_data[7:0];
                end
                cpss_pkg::CFG_STAGE_PHOTO_COUNT: begin
                    stage_photo_count_reg <= cfg_data[7:0];
                end
                cpss_pkg::CFG_NAV_SHOTS_ENABLE: begin
                    nav_shots_enable_reg <= cfg_data[0];
                end
                cpss_pkg::CFG_MANUAL_SHOTS_ENABLE: begin
                    manual_shots_enable_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Altitude thresholds at a common signed width.
    assign alt_ext     = {in_data_reg.altitude_cm[23], in_data_reg.altitude_cm};
    assign min_alt_ext = {{4{min_alt_cm_reg[20]}}, min_alt_cm_reg};
    assign alt_upper   = min_alt_ext + cpss_pkg::ALT_BAND_CM;

    // Gating, mode requests and the sequencer step for one tick.
    always_comb begin
        mode_next         = mode_reg;
        countdown_next    = countdown_reg;
        alt_enable_next   = alt_enable_reg;
        descent_hold_next = descent_hold_reg;
        shoot_en_next     = shoot_en_reg;
        stage_count_next  = stage_count_reg;
        photo_num_next    = photo_num_reg;
        shutter_next      = shutter_reg;
        switch_next       = switch_reg;
        strobe            = 1'b0;
        photo             = '0;
        want_mode         = cpss_pkg::MODE_IDLE;

        if (countdown_next != 8'd0) begin
            countdown_next = countdown_next - 8'd1;
        end

        // Altitude hysteresis and steep descent hold.
        if (in_data_reg.fix_valid) begin
            if (!min_alt_cm_reg[20]) begin
                if ((alt_ext > alt_upper) && (shot_gap_reg != 8'd0)) begin
                    alt_enable_next = 1'b1;
                end else if (alt_ext < min_alt_ext) begin
                    alt_enable_next = 1'b0;
                end
            end
            if (in_data_reg.climb_rate_cm_s < cpss_pkg::STEEP_SINK_CM_S) begin
                descent_hold_next = cpss_pkg::DESCENT_HOLD_TICKS;
            end
        end

        wanted = alt_enable_next && (descent_hold_next == 4'd0);

        // Power and shot requests; a request only lands from idle or pause.
        if (mode_next != cpss_pkg::MODE_SHOT) begin
            if (wanted != in_data_reg.camera_sense) begin
                want_mode = wanted ? cpss_pkg::MODE_TURN_ON : cpss_pkg::MODE_TURN_OFF;
                if ((want_mode != mode_next) && ((mode_next == cpss_pkg::MODE_IDLE) ||
                                                 (mode_next == cpss_pkg::MODE_PAUSE))) begin
                    mode_next      = want_mode;
                    shutter_next   = 1'b1;
                    countdown_next = 8'd0;
                end
                stage_count_next = 8'd0;
            end else if (wanted && (mode_next == cpss_pkg::MODE_IDLE) && shoot_en_next) begin
                mode_next      = cpss_pkg::MODE_SHOT;
                shutter_next   = 1'b1;
                countdown_next = 8'd0;
            end
        end

        // Shooting permission by navigation mode.
        allowed = (manual_shots_enable_reg && !in_data_reg.nav_mode) ||
                  (nav_shots_enable_reg && in_data_reg.nav_mode);
        if (allowed) begin
            if (!shoot_en_next) begin
                shoot_en_next = wanted;
            end
        end else if (shoot_en_next) begin
            shoot_en_next = 1'b0;
            if (mode_next == cpss_pkg::MODE_PAUSE) begin
                mode_next      = cpss_pkg::MODE_IDLE;
                shutter_next   = 1'b1;
                countdown_next = 8'd0;
            end
        end

        // Countdown sequencer.
        case (mode_next)
            cpss_pkg::MODE_TURN_ON: begin
                if (countdown_next == 8'd0) begin
                    countdown_next = cpss_pkg::TURN_ON_TICKS;
                    switch_next    = 1'b1;
                end else begin
                    if (countdown_next == cpss_pkg::TURN_ON_PULSE_END) begin
                        switch_next = 1'b0;
                    end
                    if ((countdown_next == 8'd1) && in_data_reg.camera_sense) begin
                        mode_next = shoot_en_next ? cpss_pkg::MODE_SHOT : cpss_pkg::MODE_IDLE;
                    end
                end
            end
            cpss_pkg::MODE_SHOT: begin
                if (countdown_next == 8'd0) begin
                    countdown_next   = cpss_pkg::SHOT_TICKS;
                    shutter_next     = 1'b0;
                    strobe           = 1'b1;
                    photo            = photo_num_next;
                    photo_num_next   = photo_num_next + 16'd1;
                    stage_count_next = stage_count_next + 8'd1;
                end else begin
                    if (countdown_next == cpss_pkg::SHOT_PULSE_END) begin
                        shutter_next = 1'b1;
                    end
                    if (countdown_next == 8'd1) begin
                        if ((stage_photo_count_reg > stage_count_next) ||
                            in_data_reg.nav_mode) begin
                            mode_next        = cpss_pkg::MODE_PAUSE;
                            stage_count_next = 8'd0;
                        end else begin
                            mode_next = cpss_pkg::MODE_TURN_OFF;
                        end
                    end
                end
            end
            cpss_pkg::MODE_TURN_OFF: begin
                if (countdown_next == 8'd0) begin
                    countdown_next = cpss_pkg::TURN_OFF_TICKS;
                end else begin
                    if (countdown_next == cpss_pkg::TURN_OFF_PULSE_ON) begin
                        switch_next = 1'b1;
                    end
                    if (countdown_next == cpss_pkg::TURN_OFF_PULSE_END) begin
                        switch_next = 1'b0;
                    end else if (!in_data_reg.camera_sense) begin
                        countdown_next = 8'd0;
                        mode_next      = cpss_pkg::MODE_IDLE;
                    end
                end
            end
            cpss_pkg::MODE_PAUSE: begin
                if (countdown_next == 8'd0) begin
                    countdown_next = shot_gap_reg - cpss_pkg::SHOT_TICKS;
                    shutter_next   = 1'b1;
                end
                if ((countdown_next == 8'd1) && shoot_en_next) begin
                    mode_next = cpss_pkg::MODE_SHOT;
                end
            end
            cpss_pkg::MODE_IDLE: begin
                stage_count_next = 8'd0;
            end
            default: begin
            end
        endcase

        if (descent_hold_next != 4'd0) begin
            descent_hold_next = descent_hold_next - 4'd1;
        end

        // Result beat.
        out_data_next.shutter_level      = shutter_next;
        out_data_next.power_switch_level = switch_next;
        out_data_next.sequencer_mode     = mode_next;
        out_data_next.shot_strobe        = strobe;
        out_data_next.photo_number       = photo;
        out_data_next.camera_wanted      = wanted;
    end

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= cpss_pkg::MODE_IDLE;
            countdown_reg    <= 8'd0;
            alt_enable_reg   <= 1'b0;
            descent_hold_reg <= 4'd0;
            shoot_en_reg     <= 1'b1;
            stage_count_reg  <= 8'd0;
            photo_num_reg    <= 16'd1;
            shutter_reg      <= 1'b1;
            switch_reg       <= 1'b0;
        end else if (advance) begin
            mode_reg         <= mode_next;
            countdown_reg    <= countdown_next;
            alt_enable_reg   <= alt_enable_next;
            descent_hold_reg <= descent_hold_next;
            shoot_en_reg     <= shoot_en_next;
            stage_count_reg  <= stage_count_next;
            photo_num_reg    <= photo_num_next;
            shutter_reg      <= shutter_next;
            switch_reg       <= switch_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    // A shot strobe always comes with the shutter pressed in shot mode.
    a_strobe_in_shot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.shot_strobe) |->
            (!m_data.shutter_level && (m_data.sequencer_mode == cpss_pkg::MODE_SHOT)))
        else $error("shot strobe without shutter pulse in shot mode");

    // The photo number is only carried on a strobe beat.
    a_photo_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.shot_strobe) |-> (m_data.photo_number == 16'd0))
        else $error("photo number set without a shot strobe");

    // A steep sink with a valid fix drops the camera request on that tick.
    a_descent_drops_want: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.fix_valid &&
         (in_data_reg.climb_rate_cm_s < cpss_pkg::STEEP_SINK_CM_S)) |=>
            !out_data_reg.camera_wanted)
        else $error("camera wanted during steep descent");
`endif

endmodule
